FILE: sv/srsg_pkg.sv
`default_nettype none

package srsg_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MOTOR_IDX_W = 3;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_TARGET = 2'd1;
	localparam logic [1:0] FUNC_HOME = 2'd2;
	localparam logic [1:0] FUNC_TABLE = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_RAMP_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RAMP_SHIFT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOME_INC = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PARKED = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DIR_POL = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERTRAVEL = 3'd5;

	localparam logic [1:0] DIR_IDLE = 2'b00;
	localparam logic [1:0] DIR_UP = 2'b01;
	localparam logic [1:0] DIR_DOWN = 2'b11;

	localparam logic [15:0] FULL_SPEED = 16'hFFFF;

	typedef struct packed {
		logic exec;
		logic tick_start;
		logic read;
		logic update;
		logic finish;
		logic [MOTOR_IDX_W-1:0] motor;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic has_steps;
	} stat_t;

endpackage

`default_nettype wire

FILE: sv/srsg_if.sv
`default_nettype none

interface srsg_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [2:0] motor_index;
	logic home_all;
	logic [11:0] target_steps;
	logic [5:0] table_index;
	logic [15:0] table_speed;

	modport source(output valid, func, motor_index, home_all, target_steps, table_index,
		table_speed, input ready);
	modport sink(input valid, func, motor_index, home_all, target_steps, table_index,
		table_speed, output ready);
endinterface

interface srsg_out_if;
	logic valid;
	logic ready;
	logic [15:0] shift_word;
	logic last;

	modport source(output valid, shift_word, last, input ready);
	modport sink(input valid, shift_word, last, output ready);
endinterface

interface srsg_cfg_if;
	logic valid;
	logic ready;
	logic [srsg_pkg::CFG_INDEX_W-1:0] index;
	logic [srsg_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/srsg_ramp_mem.sv
`default_nettype none

module srsg_ramp_mem #(
	parameter int ENTRIES = 64,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [15:0] rd_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// An entry never written reads as full speed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? rd_q : srsg_pkg::FULL_SPEED;

endmodule

`default_nettype wire

FILE: sv/srsg_dp.sv
`default_nettype none

module srsg_dp #(
	parameter int MOTORS = 8,
	parameter int RAMP_ENTRIES = 64,
	parameter int MAX_POSITION = 4095
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srsg_pkg::cmd_t                      cmd,
	output srsg_pkg::stat_t                     stat,
	input  logic                                cfg_we,
	input  logic [srsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [srsg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          func,
	input  logic [2:0]                          motor_index,
	input  logic                                home_all,
	input  logic [11:0]                         target_steps,
	input  logic [5:0]                          table_index,
	input  logic [15:0]                         table_speed,
	output logic [15:0]                         word0,
	output logic [15:0]                         word1
);

	localparam int MI_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int AW = $clog2(RAMP_ENTRIES);
	localparam logic [16:0] ENTRIES_W = 17'(RAMP_ENTRIES);
	localparam logic [16:0] LAST_ENTRY = 17'(RAMP_ENTRIES - 1);
	localparam logic [15:0] MAX_POS_W = 16'(MAX_POSITION);

	// Configuration registers.
	logic [15:0] ramp_length_q;
	logic [3:0]  ramp_shift_q;
	logic [15:0] home_inc_q;
	logic        parked_q;
	logic        dir_pol_q;
	logic [12:0] overtravel_q;

	// Per-motor state.
	logic [11:0] target_q [MOTORS];
	logic [15:0] pos_q [MOTORS];
	logic [1:0]  dir_q [MOTORS];
	logic [15:0] ramp_q [MOTORS];
	logic [15:0] phase_q [MOTORS];
	logic [MOTORS-1:0] homing_q;
	logic active_q;

	// Tick accumulation.
	logic [15:0] w_q;
	logic [15:0] sbits_q;
	logic busy_q;
	logic [15:0] last_word_q;
	logic [15:0] word0_q;
	logic [15:0] word1_q;

	// First stage of a motor visit.
	logic signed [17:0] delta_s1;
	logic [1:0]  dir_s1;
	logic [15:0] ramp_s1;
	logic [15:0] phase_s1;
	logic        homing_s1;
	logic        skip_s1;

	logic [MI_W-1:0] m;
	logic [MI_W-1:0] mi;
	logic motor_ok;
	logic table_ok;
	logic table_we;
	logic ramps_clear;
	logic [11:0] target_clamped;
	logic [8:0] tidx_ext;

	logic [11:0] goal_a;
	logic signed [17:0] delta_a;
	logic start_a;
	logic skip_a;
	logic [1:0]  dir_a;
	logic [15:0] ramp_a;
	logic [15:0] phase_a;
	logic [16:0] ridx_a;
	logic [AW-1:0] raddr;
	logic [15:0] rd_speed;

	logic [15:0] inc_b;
	logic [16:0] sum_b;
	logic carry_b;
	logic down_b;
	logic signed [17:0] dist_b;
	logic signed [17:0] d1_b;
	logic signed [17:0] r_b;
	logic [1:0]  dir_b;
	logic        hom_b;
	logic [15:0] ramp_b;
	logic        step_b;
	logic [15:0] pos_next;
	logic [3:0]  sidx;
	logic [15:0] smask;
	logic [15:0] dmask;
	logic        dir_bit;

	assign m = cmd.motor[MI_W-1:0];
	assign mi = motor_index[MI_W-1:0];
	assign motor_ok = {1'b0, motor_index} < 4'(MOTORS);
	assign tidx_ext = {3'd0, table_index};
	assign table_ok = tidx_ext < 9'(RAMP_ENTRIES);
	assign table_we = cmd.exec && (func == srsg_pkg::FUNC_TABLE) && table_ok;
	assign target_clamped = ({4'd0, target_steps} > MAX_POS_W) ? MAX_POS_W[11:0] : target_steps;
	assign ramps_clear = table_we || (cfg_we && (cfg_index == srsg_pkg::REG_RAMP_LENGTH ||
		cfg_index == srsg_pkg::REG_RAMP_SHIFT || cfg_index == srsg_pkg::REG_HOME_INC));

	// Stage A: distance to goal, motion start, table address.
	always_comb begin
		goal_a = (homing_q[m] || parked_q) ? 12'd0 : target_q[m];
		delta_a = $signed({6'd0, goal_a}) - $signed({{2{pos_q[m][15]}}, pos_q[m]});
		start_a = (dir_q[m] == srsg_pkg::DIR_IDLE) && (delta_a != 18'sd0);
		skip_a = (dir_q[m] == srsg_pkg::DIR_IDLE) && (delta_a == 18'sd0);
		dir_a = dir_q[m];
		ramp_a = ramp_q[m];
		phase_a = phase_q[m];
		if (start_a) begin
			dir_a = delta_a[17] ? srsg_pkg::DIR_DOWN : srsg_pkg::DIR_UP;
			ramp_a = '0;
			phase_a = '0;
		end
		ridx_a = {1'b0, ramp_a >> ramp_shift_q};
		raddr = (ridx_a >= ENTRIES_W) ? LAST_ENTRY[AW-1:0] : ridx_a[AW-1:0];
	end

	srsg_ramp_mem #(
		.ENTRIES(RAMP_ENTRIES)
	) u_ramp_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (table_we),
		.waddr (tidx_ext[AW-1:0]),
		.wdata (table_speed),
		.raddr (raddr),
		.rdata (rd_speed)
	);

	// Stage B: phase accumulation, ramp update, step decision.
	always_comb begin
		inc_b = homing_s1 ? home_inc_q : rd_speed;
		sum_b = {1'b0, phase_s1} + {1'b0, inc_b};
		carry_b = sum_b[16] || (inc_b == srsg_pkg::FULL_SPEED);
		down_b = (dir_s1 == srsg_pkg::DIR_DOWN);
		dist_b = down_b ? -delta_s1 : delta_s1;
		d1_b = dist_b - 18'sd1;
		r_b = $signed({2'b00, ramp_s1});
		dir_b = dir_s1;
		hom_b = homing_s1;
		ramp_b = ramp_s1;
		step_b = 1'b0;
		if (carry_b) begin
			if (dist_b <= 18'sd0) begin
				// At or past the goal: stop once the ramp has braked to zero.
				if (ramp_s1 == 16'd0) begin
					dir_b = srsg_pkg::DIR_IDLE;
					hom_b = 1'b0;
				end else begin
					ramp_b = ramp_s1 - 16'd1;
					step_b = 1'b1;
				end
			end else begin
				step_b = 1'b1;
				if (!homing_s1) begin
					if (ramp_s1 != 16'd0 && d1_b <= r_b) begin
						ramp_b = ramp_s1 - 16'd1;
					end else if (ramp_s1 < ramp_length_q && d1_b > r_b + 18'sd1) begin
						ramp_b = ramp_s1 + 16'd1;
					end
				end
			end
		end
		pos_next = pos_q[m] + (down_b ? 16'hFFFF : 16'h0001);
		sidx = {cmd.motor, 1'b0};
		smask = 16'h0001 << sidx;
		dmask = smask << 1;
		dir_bit = (down_b == dir_pol_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			delta_s1 <= delta_a;
			dir_s1 <= dir_a;
			ramp_s1 <= ramp_a;
			phase_s1 <= phase_a;
			homing_s1 <= homing_q[m];
			skip_s1 <= skip_a;
		end
		// Only a stepping tick replaces the words, so a pending result stays intact.
		if (cmd.finish && sbits_q != 16'd0) begin
			word0_q <= w_q;
			word1_q <= w_q | sbits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_length_q <= '0;
			ramp_shift_q <= '0;
			home_inc_q <= 16'hFFFF;
			parked_q <= 1'b0;
			dir_pol_q <= 1'b0;
			overtravel_q <= 13'd4095;
		end else if (cfg_we) begin
			case (cfg_index)
				srsg_pkg::REG_RAMP_LENGTH: ramp_length_q <= cfg_data[15:0];
				srsg_pkg::REG_RAMP_SHIFT: ramp_shift_q <= cfg_data[3:0];
				srsg_pkg::REG_HOME_INC: home_inc_q <= cfg_data[15:0];
				srsg_pkg::REG_PARKED: parked_q <= cfg_data[0];
				srsg_pkg::REG_DIR_POL: dir_pol_q <= cfg_data[0];
				srsg_pkg::REG_OVERTRAVEL: overtravel_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < MOTORS; n++) begin
				target_q[n] <= '0;
				pos_q[n] <= '0;
				dir_q[n] <= srsg_pkg::DIR_IDLE;
				ramp_q[n] <= '0;
				phase_q[n] <= '0;
			end
			homing_q <= '0;
		end else begin
			if (cmd.update && !skip_s1) begin
				phase_q[m] <= sum_b[15:0];
				dir_q[m] <= dir_b;
				homing_q[m] <= hom_b;
				ramp_q[m] <= ramp_b;
				if (step_b) begin
					pos_q[m] <= pos_next;
				end
			end
			if (cmd.exec) begin
				case (func)
					srsg_pkg::FUNC_TARGET: begin
						if (motor_ok) begin
							target_q[mi] <= target_clamped;
						end
					end
					srsg_pkg::FUNC_HOME: begin
						for (int n = 0; n < MOTORS; n++) begin
							if (home_all || (motor_ok && mi == MI_W'(n))) begin
								pos_q[n] <= {3'd0, overtravel_q};
								dir_q[n] <= srsg_pkg::DIR_IDLE;
								ramp_q[n] <= '0;
								homing_q[n] <= 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			if (ramps_clear) begin
				for (int n = 0; n < MOTORS; n++) begin
					ramp_q[n] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			w_q <= '0;
			sbits_q <= '0;
			busy_q <= 1'b0;
			last_word_q <= '0;
		end else begin
			if (cmd.exec) begin
				case (func)
					srsg_pkg::FUNC_TARGET: begin
						if (motor_ok) begin
							active_q <= 1'b1;
						end
					end
					srsg_pkg::FUNC_HOME: begin
						if (home_all || motor_ok) begin
							active_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cfg_we && cfg_index == srsg_pkg::REG_PARKED) begin
				active_q <= 1'b1;
			end
			if (cmd.tick_start) begin
				w_q <= last_word_q;
				sbits_q <= '0;
				busy_q <= 1'b0;
			end
			if (cmd.read && !skip_a) begin
				busy_q <= 1'b1;
			end
			if (cmd.update && !skip_s1 && step_b) begin
				w_q <= dir_bit ? ((w_q & ~smask) | dmask) : (w_q & ~smask & ~dmask);
				sbits_q <= sbits_q | smask;
			end
			if (cmd.finish) begin
				if (!busy_q) begin
					active_q <= 1'b0;
				end
				if (sbits_q != 16'd0) begin
					last_word_q <= w_q | sbits_q;
				end
			end
		end
	end

	assign stat.active = active_q;
	assign stat.has_steps = (sbits_q != 16'd0);
	assign word0 = word0_q;
	assign word1 = word1_q;

endmodule

`default_nettype wire

FILE: sv/srsg_ctrl.sv
`default_nettype none

module srsg_ctrl #(
	parameter int MOTORS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [1:0]      item_func,
	output logic            item_ready,
	output srsg_pkg::cmd_t  cmd,
	input  srsg_pkg::stat_t stat,
	output logic            result_valid,
	output logic            result_last,
	input  logic            result_ready
);

	localparam logic [srsg_pkg::MOTOR_IDX_W-1:0] LAST_MOTOR =
		srsg_pkg::MOTOR_IDX_W'(MOTORS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_EXEC = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [srsg_pkg::MOTOR_IDX_W-1:0] cnt_q, cnt_d;
	logic valid_q;
	logic last_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.motor = cnt_q;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_func == srsg_pkg::FUNC_TICK) begin
						// A tick on an idle block is dropped without a walk.
						if (stat.active) begin
							cmd.tick_start = 1'b1;
							cnt_d = '0;
							state_d = S_READ;
						end
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.update = 1'b1;
				if (cnt_q == LAST_MOTOR) begin
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
					state_d = S_READ;
				end
			end
			S_DONE: begin
				// The result buffer must be empty before two new words go in.
				if (!stat.has_steps || !valid_q) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.finish && stat.has_steps) begin
				valid_q <= 1'b1;
				last_q <= 1'b0;
			end else if (valid_q && result_ready) begin
				if (!last_q) begin
					last_q <= 1'b1;
				end else begin
					valid_q <= 1'b0;
					last_q <= 1'b0;
				end
			end
		end
	end

	assign result_valid = valid_q;
	assign result_last = last_q;

	a_finish_buffer_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && stat.has_steps |-> !valid_q)
		else $error("tick result loaded while the previous one is still pending");

	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !(cmd.read || cmd.update || cmd.finish))
		else $error("request accepted during a motor walk");

	a_read_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |=> cmd.update && $stable(cnt_q))
		else $error("motor visit did not complete its second cycle");

	a_walk_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_start |=> cmd.read && cmd.motor == '0)
		else $error("tick walk did not begin at the first motor");

endmodule

`default_nettype wire

FILE: sv/stepper_ramp_step_generator.sv
`default_nettype none

// Channel  Role   Handshake         Payload
// cfg      sink   valid / ready     index, data (register write)
// item     sink   valid / ready     func, motor_index, home_all, target_steps,
//                                   table_index, table_speed
// result   source valid / ready     shift_word, last
//
// A command request (set target, homing, table write) is accepted only in the idle state.
// A tick request on an active block walks the motors one at a time, each visit
// a state read with table lookup, then an update; the ramp table's registered
// read port splits each visit this way.
// A tick that steps loads two words into the result buffer; if that buffer still
// holds the previous tick's words, the walk's end holds until they are taken.
// Reset is asynchronous and active low; the ramp table reads full speed until written.
module stepper_ramp_step_generator #(
	parameter int MOTORS = 8,
	parameter int RAMP_ENTRIES = 64,
	parameter int MAX_POSITION = 4095
) (
	input logic         clk,
	input logic         arst_n,
	srsg_cfg_if.sink    cfg,
	srsg_in_if.sink     item,
	srsg_out_if.source  result
);

	srsg_pkg::cmd_t cmd;
	srsg_pkg::stat_t stat;
	logic item_ready;
	logic result_valid;
	logic result_last;
	logic [15:0] word0;
	logic [15:0] word1;

	assign cfg.ready = 1'b1;

	srsg_ctrl #(
		.MOTORS(MOTORS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_func   (item.func),
		.item_ready  (item_ready),
		.cmd         (cmd),
		.stat        (stat),
		.result_valid(result_valid),
		.result_last (result_last),
		.result_ready(result.ready)
	);

	srsg_dp #(
		.MOTORS      (MOTORS),
		.RAMP_ENTRIES(RAMP_ENTRIES),
		.MAX_POSITION(MAX_POSITION)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.func        (item.func),
		.motor_index (item.motor_index),
		.home_all    (item.home_all),
		.target_steps(item.target_steps),
		.table_index (item.table_index),
		.table_speed (item.table_speed),
		.word0       (word0),
		.word1       (word1)
	);

	assign item.ready = item_ready;
	assign result.valid = result_valid;
	assign result.last = result_last;
	assign result.shift_word = result_last ? word1 : word0;

endmodule

`default_nettype wire

FILE: tb/sv/tb_stepper_ramp_step_generator.sv
`default_nettype none

module tb_stepper_ramp_step_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MOTORS = 8;
	localparam int RAMP_ENTRIES = 64;
	localparam int MAX_POSITION = 4095;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS = 380;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  motor;
		logic        all;
		logic [11:0] steps;
		logic [5:0]  tidx;
		logic [15:0] speed;
	} request_t;

	typedef struct packed {
		logic [15:0] word;
		logic        last;
	} drive_word_t;

	logic clk = 1'b0;
	logic arst_n;

	srsg_cfg_if cfg_ch();
	srsg_in_if  item_ch();
	srsg_out_if res_ch();

	stepper_ramp_step_generator #(
		.MOTORS(MOTORS),
		.RAMP_ENTRIES(RAMP_ENTRIES),
		.MAX_POSITION(MAX_POSITION)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.item(item_ch),
		.result(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block's registers and motor state.
	logic [15:0] r_ramp_len;
	logic [3:0]  r_shift;
	logic [15:0] r_home_inc;
	logic        r_parked;
	logic        r_dir_pol;
	logic [12:0] r_overtravel;

	logic [11:0] goal_pos [MOTORS];
	logic [15:0] cur_pos [MOTORS];
	logic [1:0]  heading [MOTORS];
	logic [15:0] ramp_cnt [MOTORS];
	logic [15:0] accum [MOTORS];
	logic        seeking_home [MOTORS];
	logic [15:0] speed_tab [RAMP_ENTRIES];
	logic [15:0] held_word;
	logic        awake;

	drive_word_t step_words [$];
	int mismatches = 0;
	bit calm = 1'b0;
	int hold_req = 0;
	int stall_left = 0;

	task automatic mirror_reset();
		r_ramp_len = '0;
		r_shift = '0;
		r_home_inc = srsg_pkg::FULL_SPEED;
		r_parked = 1'b0;
		r_dir_pol = 1'b0;
		r_overtravel = 13'd4095;
		for (int n = 0; n < MOTORS; n++) begin
			goal_pos[n] = '0;
			cur_pos[n] = '0;
			heading[n] = srsg_pkg::DIR_IDLE;
			ramp_cnt[n] = '0;
			accum[n] = '0;
			seeking_home[n] = 1'b0;
		end
		for (int i = 0; i < RAMP_ENTRIES; i++)
			speed_tab[i] = srsg_pkg::FULL_SPEED;
		held_word = '0;
		awake = 1'b0;
	endtask

	task automatic clear_ramps();
		for (int n = 0; n < MOTORS; n++)
			ramp_cnt[n] = '0;
	endtask

	task automatic begin_homing(int n);
		cur_pos[n] = {3'b000, r_overtravel};
		heading[n] = srsg_pkg::DIR_IDLE;
		ramp_cnt[n] = '0;
		seeking_home[n] = 1'b1;
		awake = 1'b1;
	endtask

	task automatic apply_register(logic [srsg_pkg::CFG_INDEX_W-1:0] idx,
		logic [srsg_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			srsg_pkg::REG_RAMP_LENGTH: begin
				r_ramp_len = data;
				clear_ramps();
			end
			srsg_pkg::REG_RAMP_SHIFT: begin
				r_shift = data[3:0];
				clear_ramps();
			end
			srsg_pkg::REG_HOME_INC: begin
				r_home_inc = data;
				clear_ramps();
			end
			srsg_pkg::REG_PARKED: begin
				r_parked = data[0];
				awake = 1'b1;
			end
			srsg_pkg::REG_DIR_POL: r_dir_pol = data[0];
			srsg_pkg::REG_OVERTRAVEL: r_overtravel = data[12:0];
			default: ;
		endcase
	endtask

	// One tick: walk every motor, accumulate phase, step on carry and queue the
	// two driver words when anything stepped.
	task automatic predict_tick();
		logic [15:0] w;
		logic [15:0] step_bits;
		logic [15:0] inc;
		logic [16:0] sum;
		logic busy;
		logic down;
		int goal;
		int delta;
		int span;
		int r;
		int idx;
		if (!awake)
			return;
		w = held_word;
		step_bits = '0;
		busy = 1'b0;
		for (int n = 0; n < MOTORS; n++) begin
			goal = (seeking_home[n] || r_parked) ? 0 : int'(goal_pos[n]);
			delta = goal - int'($signed(cur_pos[n]));
			if (heading[n] == srsg_pkg::DIR_IDLE) begin
				if (delta == 0)
					continue;
				heading[n] = (delta > 0) ? srsg_pkg::DIR_UP : srsg_pkg::DIR_DOWN;
				ramp_cnt[n] = '0;
				accum[n] = '0;
			end
			busy = 1'b1;
			inc = r_home_inc;
			if (!seeking_home[n]) begin
				idx = int'(ramp_cnt[n] >> r_shift);
				if (idx >= RAMP_ENTRIES)
					idx = RAMP_ENTRIES - 1;
				inc = speed_tab[idx];
			end
			sum = {1'b0, accum[n]} + {1'b0, inc};
			accum[n] = sum[15:0];
			if (!sum[16] && inc != srsg_pkg::FULL_SPEED)
				continue;
			span = (heading[n] == srsg_pkg::DIR_UP) ? delta : -delta;
			if (span <= 0) begin
				// At or past the goal: brake down first, stop only at ramp zero.
				if (ramp_cnt[n] == 0) begin
					heading[n] = srsg_pkg::DIR_IDLE;
					seeking_home[n] = 1'b0;
					continue;
				end
				ramp_cnt[n] = ramp_cnt[n] - 16'd1;
			end else if (!seeking_home[n]) begin
				r = int'(ramp_cnt[n]);
				span = span - 1;
				if (r > 0 && span <= r)
					ramp_cnt[n] = ramp_cnt[n] - 16'd1;
				else if (ramp_cnt[n] < r_ramp_len && span > r + 1)
					ramp_cnt[n] = ramp_cnt[n] + 16'd1;
			end
			down = (heading[n] == srsg_pkg::DIR_DOWN);
			cur_pos[n] = down ? cur_pos[n] - 16'd1 : cur_pos[n] + 16'd1;
			w[2*n] = 1'b0;
			w[2*n+1] = (down == r_dir_pol);
			step_bits[2*n] = 1'b1;
		end
		if (!busy)
			awake = 1'b0;
		if (step_bits == '0)
			return;
		step_words.push_back({w, 1'b0});
		w = w | step_bits;
		step_words.push_back({w, 1'b1});
		held_word = w;
	endtask

	task automatic predict_request(request_t rq);
		case (rq.func)
			srsg_pkg::FUNC_TICK: predict_tick();
			srsg_pkg::FUNC_TARGET: begin
				goal_pos[rq.motor] = (rq.steps > MAX_POSITION) ? 12'(MAX_POSITION) : rq.steps;
				awake = 1'b1;
			end
			srsg_pkg::FUNC_HOME: begin
				if (rq.all) begin
					for (int n = 0; n < MOTORS; n++)
						begin_homing(n);
				end else begin
					begin_homing(int'(rq.motor));
				end
			end
			default: begin
				if (rq.tidx < RAMP_ENTRIES) begin
					speed_tab[rq.tidx] = rq.speed;
					clear_ramps();
				end
			end
		endcase
	endtask

	function automatic request_t noise_request();
		request_t rq;
		rq.func = 2'($urandom);
		rq.motor = 3'($urandom);
		rq.all = 1'($urandom);
		rq.steps = 12'($urandom);
		rq.tidx = 6'($urandom);
		rq.speed = 16'($urandom);
		return rq;
	endfunction

	function automatic logic [11:0] near_goal(int m, int offset);
		int v;
		v = int'($signed(cur_pos[m])) + offset;
		if (v < 0)
			v = 0;
		if (v > MAX_POSITION)
			v = MAX_POSITION;
		return 12'(v);
	endfunction

	task automatic send_request(request_t rq);
		int gap;
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.func <= rq.func;
		item_ch.motor_index <= rq.motor;
		item_ch.home_all <= rq.all;
		item_ch.target_steps <= rq.steps;
		item_ch.table_index <= rq.tidx;
		item_ch.table_speed <= rq.speed;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predict_request(rq);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_tick();
		request_t rq;
		rq = noise_request();
		rq.func = srsg_pkg::FUNC_TICK;
		send_request(rq);
	endtask

	task automatic send_target(int m, logic [11:0] steps);
		request_t rq;
		rq = noise_request();
		rq.func = srsg_pkg::FUNC_TARGET;
		rq.motor = 3'(m);
		rq.steps = steps;
		send_request(rq);
	endtask

	task automatic send_home(int m, logic all);
		request_t rq;
		rq = noise_request();
		rq.func = srsg_pkg::FUNC_HOME;
		rq.motor = 3'(m);
		rq.all = all;
		send_request(rq);
	endtask

	task automatic send_table(int idx, logic [15:0] speed);
		request_t rq;
		rq = noise_request();
		rq.func = srsg_pkg::FUNC_TABLE;
		rq.tidx = 6'(idx);
		rq.speed = speed;
		send_request(rq);
	endtask

	task automatic write_reg(logic [srsg_pkg::CFG_INDEX_W-1:0] idx,
		logic [srsg_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		apply_register(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// A tick with no step leaves no trace in the queue, so give the motor walk
	// time to finish after the last word.
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (step_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_commands();
		write_reg(srsg_pkg::REG_OVERTRAVEL, 16'd2);
		write_reg(srsg_pkg::REG_HOME_INC, srsg_pkg::FULL_SPEED);
		// The block is still asleep, so this tick must not produce words.
		send_tick();
		send_target(0, 12'd4095);
		send_target(7, 12'd1);
		repeat (2) send_tick();
		send_target(0, 12'd0);
		repeat (3) send_tick();
	endtask

	task automatic test_braking_overshoot();
		drain();
		write_reg(srsg_pkg::REG_RAMP_LENGTH, 16'd60000);
		send_target(4, 12'd8);
		repeat (3) send_tick();
		// The target jumps behind a motor that is still ramped up.
		send_target(4, 12'd0);
		repeat (6) send_tick();
	endtask

	task automatic test_homing_edges();
		drain();
		write_reg(srsg_pkg::REG_OVERTRAVEL, 16'd0);
		send_home(2, 1'b0);
		send_target(2, 12'd5);
		send_tick();
		drain();
		write_reg(srsg_pkg::REG_OVERTRAVEL, 16'd2);
		send_home(0, 1'b1);
		send_table(63, 16'd0);
		send_table(0, 16'h8000);
		repeat (3) send_tick();
	endtask

	task automatic test_parking();
		drain();
		write_reg(srsg_pkg::REG_DIR_POL, 16'd1);
		write_reg(srsg_pkg::REG_RAMP_SHIFT, 16'd15);
		send_target(3, 12'd3);
		repeat (2) send_tick();
		drain();
		write_reg(srsg_pkg::REG_PARKED, 16'd1);
		repeat (3) send_tick();
		drain();
		write_reg(srsg_pkg::REG_PARKED, 16'd0);
	endtask

	task automatic test_backpressure();
		drain();
		write_reg(srsg_pkg::REG_RAMP_LENGTH, 16'd0);
		send_table(0, srsg_pkg::FULL_SPEED);
		for (int m = 0; m < MOTORS; m++)
			send_target(m, near_goal(m, 100));
		hold_req = 300;
		repeat (30) send_tick();
	endtask

	function automatic logic [15:0] pick_reg_value(logic [srsg_pkg::CFG_INDEX_W-1:0] idx);
		case (idx)
			srsg_pkg::REG_RAMP_LENGTH: begin
				case ($urandom_range(0, 3))
					0: return 16'd0;
					1: return 16'($urandom_range(1, 64));
					2: return 16'd60000;
					default: return 16'($urandom_range(0, 60000));
				endcase
			end
			srsg_pkg::REG_RAMP_SHIFT: begin
				case ($urandom_range(0, 3))
					0: return 16'd0;
					1: return 16'd15;
					default: return 16'($urandom_range(0, 4));
				endcase
			end
			srsg_pkg::REG_HOME_INC: begin
				case ($urandom_range(0, 7))
					0: return 16'd0;
					1, 2, 3, 4: return srsg_pkg::FULL_SPEED;
					default: return 16'($urandom);
				endcase
			end
			srsg_pkg::REG_PARKED: return ($urandom_range(0, 4) == 0) ? 16'd1 : 16'd0;
			srsg_pkg::REG_DIR_POL: return 16'($urandom_range(0, 1));
			default: return ($urandom_range(0, 5) == 0) ? 16'd8191 : 16'($urandom_range(0, 24));
		endcase
	endfunction

	// Cruise phases keep one setting long enough for the ramp to climb past
	// the end of the table; mixed phases shuffle the settings and commands.
	task automatic run_phase(bit cruise, int items, ref int sent);
		int k;
		int m;
		drain();
		if (cruise) begin
			write_reg(srsg_pkg::REG_RAMP_LENGTH, 16'd60000);
			write_reg(srsg_pkg::REG_RAMP_SHIFT, 16'd0);
			write_reg(srsg_pkg::REG_PARKED, 16'd0);
		end else begin
			for (int r = srsg_pkg::REG_RAMP_LENGTH; r <= srsg_pkg::REG_OVERTRAVEL; r++) begin
				if ($urandom_range(0, 1) == 0)
					write_reg(r[srsg_pkg::CFG_INDEX_W-1:0],
						pick_reg_value(r[srsg_pkg::CFG_INDEX_W-1:0]));
			end
		end
		for (int i = 0; i < items; i++) begin
			k = $urandom_range(0, 99);
			m = $urandom_range(0, MOTORS - 1);
			if (cruise) begin
				if (k < 95)
					send_tick();
				else
					send_target(m, near_goal(m, 300));
			end else if (k < 62) begin
				send_tick();
			end else if (k < 82) begin
				if ($urandom_range(0, 3) == 0)
					send_target(m, 12'($urandom));
				else
					send_target(m, near_goal(m, int'($urandom_range(0, 80)) - 40));
			end else if (k < 87) begin
				send_home(m, ($urandom_range(0, 2) == 0));
			end else begin
				if ($urandom_range(0, 1) == 0)
					send_table($urandom_range(0, RAMP_ENTRIES - 1),
						16'($urandom_range(16'h4000, 16'hFFFF)));
				else
					send_table($urandom_range(0, RAMP_ENTRIES - 1), 16'($urandom));
			end
			sent++;
		end
	endtask

	task automatic test_random_mix();
		int sent;
		int left;
		sent = 0;
		while (sent < RANDOM_ITEMS - 40) begin
			left = RANDOM_ITEMS - 40 - sent;
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0)
				run_phase(1'b1, (left < 100) ? left : 100, sent);
			else
				run_phase(1'b0, (left < 50) ? left : 50, sent);
		end
		calm = 1'b1;
		run_phase(1'b0, 40, sent);
	endtask

	// Result receiver: random stall bursts plus the long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_req > 0) begin
			res_ch.ready <= 1'b0;
			hold_req = hold_req - 1;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			res_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 7);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	function automatic void note_mismatch(string what, logic [15:0] want, logic [15:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
	endfunction

	always @(posedge clk) begin
		drive_word_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (step_words.size() == 0) begin
				note_mismatch("unexpected word", 16'h0, res_ch.shift_word);
			end else begin
				want = step_words.pop_front();
				if (res_ch.shift_word !== want.word)
					note_mismatch("shift_word", want.word, res_ch.shift_word);
				if (res_ch.last !== want.last)
					note_mismatch("last", 16'(want.last), 16'(res_ch.last));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("FAIL stepper_ramp_step_generator");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.func = srsg_pkg::FUNC_TICK;
		item_ch.motor_index = '0;
		item_ch.home_all = 1'b0;
		item_ch.target_steps = '0;
		item_ch.table_index = '0;
		item_ch.table_speed = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = srsg_pkg::REG_RAMP_LENGTH;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		mirror_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_commands();
		test_braking_overshoot();
		test_homing_edges();
		test_parking();
		test_backpressure();
		test_random_mix();

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && step_words.size() == 0) begin
			$display("PASS stepper_ramp_step_generator");
		end else begin
			$display("FAIL stepper_ramp_step_generator");
		end
		$finish;
	end

endmodule

`default_nettype wire
